### hw/rtl/dpb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpb_pkg
// Shared widths, types, register codes and arithmetic helpers for the depth
// pixel back-projection pipeline.
// ---------------------------------------------------------------------------
package dpb_pkg;

    // pixel coordinate width, sets the column and row ports
    localparam int COORD_BITS = 12;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int FOCAL_W    = 24;
    localparam int CENTER_W   = 20;
    localparam int POINT_W    = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // magnitude of (coord * 256 - center), product with depth, divider remainder
    localparam int POS_W  = COORD_BITS + 8;
    localparam int MAG_W  = (POS_W > CENTER_W) ? POS_W : CENTER_W;
    localparam int PROD_W = MAG_W + DEPTH_W;
    localparam int REM_W  = FOCAL_W;

    // one restoring step per quotient bit
    localparam int DIV_STEPS = PROD_W;

    // register reset values (459.5, about 332.7, 259.0 in Q.8)
    localparam logic [FOCAL_W-1:0]  FOCAL_RESET    = 24'd117632;
    localparam logic [CENTER_W-1:0] CENTER_X_RESET = 20'd85171;
    localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 20'd66304;

    typedef logic [MAG_W-1:0]   t_mag;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [REM_W-1:0]   t_rem;
    typedef logic [FOCAL_W-1:0] t_focal;

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL    = 2'd0,
        CFG_CENTER_X = 2'd1,
        CFG_CENTER_Y = 2'd2,
        CFG_GRAY     = 2'd3
    } t_cfg_idx;

    // per-pixel sideband that rides along with the arithmetic
    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_side;

    // partial remainder and dividend/quotient shift word of one divider lane
    typedef struct packed {
        t_rem  rem;
        t_prod dvd;
    } t_div;

    // one restoring division step: shift in a dividend bit, subtract if it fits
    function automatic t_div div_step(t_div s, t_focal d);
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        logic           ge;
        t_div           r;
        trial = {s.rem, s.dvd[PROD_W-1]};
        diff  = trial - {1'b0, d};
        ge    = (trial >= {1'b0, d});
        r.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        r.dvd = {s.dvd[PROD_W-2:0], ge};
        return r;
    endfunction

    // apply the sign and clamp to the signed 32-bit range
    function automatic logic [POINT_W-1:0] saturate(t_prod q, logic neg);
        logic                ovf_pos;
        logic                ovf_neg;
        logic [POINT_W-1:0]  r;
        ovf_pos = |q[PROD_W-1:POINT_W-1];
        ovf_neg = (|q[PROD_W-1:POINT_W]) || (q[POINT_W-1] && (|q[POINT_W-2:0]));
        if (neg) begin
            r = ovf_neg ? {1'b1, {(POINT_W-1){1'b0}}} : (POINT_W'(0) - q[POINT_W-1:0]);
        end else begin
            r = ovf_pos ? {1'b0, {(POINT_W-1){1'b1}}} : q[POINT_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/dpb_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpb_front
// Input register with centering and colour select, then the depth multiply.
// Two register stages; zero-depth pixels are dropped here.
// ---------------------------------------------------------------------------
module dpb_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [dpb_pkg::COORD_BITS-1:0]    i_col,
    input  logic [dpb_pkg::COORD_BITS-1:0]    i_row,
    input  logic [dpb_pkg::DEPTH_W-1:0]       i_depth,
    input  logic [dpb_pkg::COLOR_W-1:0]       i_byte0,
    input  logic [dpb_pkg::COLOR_W-1:0]       i_byte1,
    input  logic [dpb_pkg::COLOR_W-1:0]       i_byte2,
    input  logic [dpb_pkg::CENTER_W-1:0]      i_center_x,
    input  logic [dpb_pkg::CENTER_W-1:0]      i_center_y,
    input  logic                              i_gray,
    output logic                              o_valid,
    output dpb_pkg::t_prod                    o_prod_x,
    output dpb_pkg::t_prod                    o_prod_y,
    output dpb_pkg::t_side                    o_side
);

    logic           r_a_valid;
    dpb_pkg::t_mag  r_a_mag_x;
    dpb_pkg::t_mag  r_a_mag_y;
    dpb_pkg::t_side r_a_side;
    logic           r_b_valid;
    dpb_pkg::t_prod r_b_prod_x;
    dpb_pkg::t_prod r_b_prod_y;
    dpb_pkg::t_side r_b_side;

    dpb_pkg::t_mag  n_pos_x;
    dpb_pkg::t_mag  n_pos_y;
    dpb_pkg::t_mag  n_cx;
    dpb_pkg::t_mag  n_cy;
    dpb_pkg::t_mag  n_mag_x;
    dpb_pkg::t_mag  n_mag_y;
    dpb_pkg::t_side n_side;

    // centering: |coord * 256 - center| and its sign, colour byte routing
    always_comb begin
        n_pos_x      = dpb_pkg::t_mag'({i_col, 8'h00});
        n_pos_y      = dpb_pkg::t_mag'({i_row, 8'h00});
        n_cx         = dpb_pkg::t_mag'(i_center_x);
        n_cy         = dpb_pkg::t_mag'(i_center_y);
        n_side.neg_x = (n_pos_x < n_cx);
        n_side.neg_y = (n_pos_y < n_cy);
        n_mag_x      = n_side.neg_x ? (n_cx - n_pos_x) : (n_pos_x - n_cx);
        n_mag_y      = n_side.neg_y ? (n_cy - n_pos_y) : (n_pos_y - n_cy);
        n_side.depth = i_depth;
        n_side.blue  = i_byte0;
        n_side.green = i_gray ? i_byte0 : i_byte1;
        n_side.red   = i_gray ? i_byte0 : i_byte2;
    end

    // stage a and b valid: pixels without a depth sample become a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid && (i_depth != '0);
            r_b_valid <= r_a_valid;
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag_x <= n_mag_x;
            r_a_mag_y <= n_mag_y;
            r_a_side  <= n_side;
        end
    end

    // stage b: magnitude times depth, exact
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_prod_x <= dpb_pkg::t_prod'(r_a_mag_x) * dpb_pkg::t_prod'(r_a_side.depth);
            r_b_prod_y <= dpb_pkg::t_prod'(r_a_mag_y) * dpb_pkg::t_prod'(r_a_side.depth);
            r_b_side   <= r_a_side;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_prod_x = r_b_prod_x;
    assign o_prod_y = r_b_prod_y;
    assign o_side   = r_b_side;

endmodule

### hw/rtl/dpb_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpb_divider
// Pipelined restoring divider, one quotient bit per stage, two lanes (x, y)
// sharing the focal-length divisor. Sideband and valid travel with the data.
// ---------------------------------------------------------------------------
module dpb_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  dpb_pkg::t_prod   i_prod_x,
    input  dpb_pkg::t_prod   i_prod_y,
    input  dpb_pkg::t_side   i_side,
    input  dpb_pkg::t_focal  i_focal,
    output logic             o_valid,
    output dpb_pkg::t_prod   o_quo_x,
    output dpb_pkg::t_prod   o_quo_y,
    output dpb_pkg::t_side   o_side
);

    logic [dpb_pkg::DIV_STEPS-1:0] r_valid;
    dpb_pkg::t_div                 r_x    [dpb_pkg::DIV_STEPS];
    dpb_pkg::t_div                 r_y    [dpb_pkg::DIV_STEPS];
    dpb_pkg::t_side                r_side [dpb_pkg::DIV_STEPS];

    genvar g;
    for (g = 0; g < dpb_pkg::DIV_STEPS; g++) begin : g_step
        logic           valid_in;
        dpb_pkg::t_div  x_in;
        dpb_pkg::t_div  y_in;
        dpb_pkg::t_side side_in;
        dpb_pkg::t_div  n_x;
        dpb_pkg::t_div  n_y;

        // stage input: from the multiplier or from the previous step
        if (g == 0) begin : g_first
            assign valid_in = i_valid;
            assign x_in     = {dpb_pkg::t_rem'(0), i_prod_x};
            assign y_in     = {dpb_pkg::t_rem'(0), i_prod_y};
            assign side_in  = i_side;
        end else begin : g_next
            assign valid_in = r_valid[g-1];
            assign x_in     = r_x[g-1];
            assign y_in     = r_y[g-1];
            assign side_in  = r_side[g-1];
        end

        assign n_x = dpb_pkg::div_step(x_in, i_focal);
        assign n_y = dpb_pkg::div_step(y_in, i_focal);

        // step valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= valid_in;
            end
        end

        // step payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_side[g] <= side_in;
            end
        end
    end

    // after the last step the shift word holds the whole quotient
    assign o_valid = r_valid[dpb_pkg::DIV_STEPS-1];
    assign o_quo_x = r_x[dpb_pkg::DIV_STEPS-1].dvd;
    assign o_quo_y = r_y[dpb_pkg::DIV_STEPS-1].dvd;
    assign o_side  = r_side[dpb_pkg::DIV_STEPS-1];

endmodule

### hw/rtl/depth_pixel_backprojection_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_pixel_backprojection_top
// Pinhole back-projection of depth pixels into colored 3-D points.
// ---------------------------------------------------------------------------
// Takes one pixel beat per clock and returns x = (col - cx) * depth / f,
// y = (row - cy) * depth / f and z = depth, in depth units, with x and y
// truncated toward zero and clamped to signed 32 bits; pixels with zero depth
// are consumed and give no point. Throughput is one pixel per clock while the
// output is not stalled. The pipeline registers are two front stages
// (centering, depth multiply), one restoring divider stage per quotient bit,
// and the output register. A stalled output freezes the whole pipeline, so
// o_in_stall follows i_out_stall while a point is waiting. The configuration
// port is always ready; write it only while no pixel is in flight. A focal
// length of zero is taken as one.
// ---------------------------------------------------------------------------
module depth_pixel_backprojection_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [dpb_pkg::COORD_BITS-1:0]     i_col,
    input  logic [dpb_pkg::COORD_BITS-1:0]     i_row,
    input  logic [dpb_pkg::DEPTH_W-1:0]        i_depth,
    input  logic [dpb_pkg::COLOR_W-1:0]        i_byte0,
    input  logic [dpb_pkg::COLOR_W-1:0]        i_byte1,
    input  logic [dpb_pkg::COLOR_W-1:0]        i_byte2,
    // point channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [dpb_pkg::POINT_W-1:0] o_point_x,
    output logic signed [dpb_pkg::POINT_W-1:0] o_point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]        o_point_z,
    output logic [dpb_pkg::COLOR_W-1:0]        o_red,
    output logic [dpb_pkg::COLOR_W-1:0]        o_green,
    output logic [dpb_pkg::COLOR_W-1:0]        o_blue,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [dpb_pkg::FOCAL_W-1:0]  r_focal;
    logic [dpb_pkg::CENTER_W-1:0] r_center_x;
    logic [dpb_pkg::CENTER_W-1:0] r_center_y;
    logic                         r_gray;

    logic                         r_out_valid;
    logic [dpb_pkg::POINT_W-1:0]  r_out_x;
    logic [dpb_pkg::POINT_W-1:0]  r_out_y;
    dpb_pkg::t_side               r_out_side;

    logic                         w_en;
    dpb_pkg::t_focal              w_focal_eff;
    logic                         w_front_valid;
    dpb_pkg::t_prod               w_prod_x;
    dpb_pkg::t_prod               w_prod_y;
    dpb_pkg::t_side               w_front_side;
    logic                         w_div_valid;
    dpb_pkg::t_prod               w_quo_x;
    dpb_pkg::t_prod               w_quo_y;
    dpb_pkg::t_side               w_div_side;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal    <= dpb_pkg::FOCAL_RESET;
            r_center_x <= dpb_pkg::CENTER_X_RESET;
            r_center_y <= dpb_pkg::CENTER_Y_RESET;
            r_gray     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dpb_pkg::t_cfg_idx'(i_cfg_index))
                dpb_pkg::CFG_FOCAL:    r_focal    <= i_cfg_data[dpb_pkg::FOCAL_W-1:0];
                dpb_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::CFG_GRAY:     r_gray     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_focal_eff = (r_focal == '0) ? dpb_pkg::t_focal'(1) : r_focal;

    // pipeline advance: hold everything while a point waits at a stalled output
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    dpb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in_valid),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_depth    (i_depth),
        .i_byte0    (i_byte0),
        .i_byte1    (i_byte1),
        .i_byte2    (i_byte2),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_gray     (r_gray),
        .o_valid    (w_front_valid),
        .o_prod_x   (w_prod_x),
        .o_prod_y   (w_prod_y),
        .o_side     (w_front_side)
    );

    dpb_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_front_valid),
        .i_prod_x (w_prod_x),
        .i_prod_y (w_prod_y),
        .i_side   (w_front_side),
        .i_focal  (w_focal_eff),
        .o_valid  (w_div_valid),
        .o_quo_x  (w_quo_x),
        .o_quo_y  (w_quo_y),
        .o_side   (w_div_side)
    );

    // output register: sign, clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x    <= dpb_pkg::saturate(w_quo_x, w_div_side.neg_x);
            r_out_y    <= dpb_pkg::saturate(w_quo_y, w_div_side.neg_y);
            r_out_side <= w_div_side;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r_out_side.depth;
    assign o_red       = r_out_side.red;
    assign o_green     = r_out_side.green;
    assign o_blue      = r_out_side.blue;

    // a point never carries zero depth
    a_no_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_point_z != '0))
        else $error("point with zero depth");

    // input stalls only behind a stalled, waiting point
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a divider result moving forward lands in the output register
    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_div_valid) |=> o_out_valid)
        else $error("divider result lost");

    // a point at or right of the center never comes out with a negative x
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_out_side.neg_x) |-> !o_point_x[dpb_pkg::POINT_W-1])
        else $error("x sign flipped");

endmodule
